@@ design/counted_step_and_servo_pwm_defines.svh @@
// ----------------------------------------------------------------------------
// counted_step_and_servo_pwm assertion macros
// shared concurrent assertion forms on clk with synchronous rst
// ----------------------------------------------------------------------------
`ifndef COUNTED_STEP_AND_SERVO_PWM_DEFINES_SVH
`define COUNTED_STEP_AND_SERVO_PWM_DEFINES_SVH

// condition must hold at every edge out of reset
`define CSPWM_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("cspwm invariant violated");

// antecedent in one cycle implies consequent in the next
`define CSPWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cspwm next-cycle check violated");

`endif

@@ design/cspwm_pkg.sv @@
// ----------------------------------------------------------------------------
// cspwm_pkg
// types and constants of the counted step and servo pwm timer
// ----------------------------------------------------------------------------
package cspwm_pkg;

  localparam int MODE_BITS  = 3;
  localparam int STEPS_BITS = 32;
  localparam int DELAY_BITS = 17;
  localparam int WIDTH_BITS = 16;
  localparam int CFG_BITS   = 16;
  localparam int CFG_IDX_BITS = 1;

  localparam int RESET_PERIOD    = 20000 - 1;
  localparam int RESET_SERVO_CMP = 1500;
  localparam logic [CFG_BITS-1:0] RESET_SERVO_MIN = 16'd500;
  localparam logic [CFG_BITS-1:0] RESET_SERVO_MAX = 16'd2500;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_TICK  = 3'd0,
    MODE_START = 3'd1,
    MODE_STOP  = 3'd2,
    MODE_SERVO = 3'd3,
    MODE_CLEAR = 3'd4
  } mode_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SERVO_MIN = 1'b0,
    REG_SERVO_MAX = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [MODE_BITS-1:0]  mode;
    logic [STEPS_BITS-1:0] step_count;
    logic [DELAY_BITS-1:0] step_delay;
    logic [WIDTH_BITS-1:0] servo_width;
  } cmd_item_t;

  typedef struct packed {
    logic                  step_pin;
    logic                  servo_pin;
    logic                  move_done;
    logic                  moving;
    logic [STEPS_BITS-1:0] steps_left;
  } rsp_item_t;

endpackage

@@ design/cspwm_if.sv @@
// ----------------------------------------------------------------------------
// cspwm channel interfaces
// valid/ready channels for command requests and status responses
// ----------------------------------------------------------------------------
interface cspwm_cmd_if import cspwm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [MODE_BITS-1:0]  mode;
  logic [STEPS_BITS-1:0] step_count;
  logic [DELAY_BITS-1:0] step_delay;
  logic [WIDTH_BITS-1:0] servo_width;

  modport source(output valid, mode, step_count, step_delay, servo_width, input ready);
  modport sink(input valid, mode, step_count, step_delay, servo_width, output ready);
endinterface

interface cspwm_rsp_if import cspwm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  step_pin;
  logic                  servo_pin;
  logic                  move_done;
  logic                  moving;
  logic [STEPS_BITS-1:0] steps_left;

  modport source(output valid, step_pin, servo_pin, move_done, moving, steps_left,
                 input ready);
  modport sink(input valid, step_pin, servo_pin, move_done, moving, steps_left,
               output ready);
endinterface

@@ design/cspwm_in_stage.sv @@
// ----------------------------------------------------------------------------
// cspwm_in_stage
// input register: captures one command request and holds it until consumed
// ----------------------------------------------------------------------------
module cspwm_in_stage import cspwm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  cspwm_cmd_if.sink   cmd,
  input  logic        advance,
  output logic        item_valid,
  output cmd_item_t   item
);

  logic take;

  assign cmd.ready = !item_valid || advance;
  assign take      = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.mode        <= cmd.mode;
      item.step_count  <= cmd.step_count;
      item.step_delay  <= cmd.step_delay;
      item.servo_width <= cmd.servo_width;
    end
  end

endmodule

@@ design/cspwm_core.sv @@
// ----------------------------------------------------------------------------
// cspwm_core
// timer state, config registers and single-pass command update
// ----------------------------------------------------------------------------
`include "counted_step_and_servo_pwm_defines.svh"

module cspwm_core import cspwm_pkg::*; #(
  parameter int COUNTER_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  input  logic                    advance,
  input  cmd_item_t               item,
  output rsp_item_t               result
);

  localparam int CB = COUNTER_BITS;
  localparam int DW = (CB + 1 > DELAY_BITS) ? CB + 1 : DELAY_BITS;
  localparam logic [CB-1:0] PERIOD_RST = CB'(RESET_PERIOD);
  localparam logic [CB-1:0] SERVO_RST  = CB'(RESET_SERVO_CMP);
  localparam logic [DW-1:0] SPAN       = DW'(1) << CB;

  logic [CFG_BITS-1:0] servo_min;
  logic [CFG_BITS-1:0] servo_max;

  logic [CB-1:0]         tick_counter, tick_counter_next;
  logic [CB-1:0]         period_active, period_active_next;
  logic [CB-1:0]         period_pending, period_pending_next;
  logic [CB-1:0]         step_cmp_active, step_cmp_active_next;
  logic [CB-1:0]         step_cmp_pending, step_cmp_pending_next;
  logic [CB-1:0]         servo_cmp_active, servo_cmp_active_next;
  logic [CB-1:0]         servo_cmp_pending, servo_cmp_pending_next;
  logic [STEPS_BITS-1:0] remaining_steps, remaining_steps_next;
  logic                  counting_on, counting_on_next;
  logic                  step_out_enable, step_out_enable_next;
  logic                  done_flag, done_flag_next;

  logic [DW-1:0]         delay_ext;
  logic [DW-1:0]         delay_sat;
  logic [CB-1:0]         period_new;
  logic [WIDTH_BITS-1:0] width_lo;
  logic [WIDTH_BITS-1:0] width_clamped;
  logic [STEPS_BITS-1:0] steps_dec;
  logic                  wrap;
  logic                  is_tick;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      servo_min <= RESET_SERVO_MIN;
      servo_max <= RESET_SERVO_MAX;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SERVO_MIN: servo_min <= cfg_data;
        REG_SERVO_MAX: servo_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // operand preparation
  always_comb begin
    delay_ext     = DW'(item.step_delay);
    delay_sat     = (delay_ext > SPAN) ? SPAN : delay_ext;
    period_new    = CB'(delay_sat - DW'(1));
    width_lo      = (item.servo_width < servo_min) ? servo_min : item.servo_width;
    width_clamped = (width_lo > servo_max) ? servo_max : width_lo;
    steps_dec     = remaining_steps - STEPS_BITS'(1);
    wrap          = tick_counter >= period_active;
    is_tick       = advance && (mode_t'(item.mode) == MODE_TICK);
  end

  // next state
  always_comb begin
    tick_counter_next      = tick_counter;
    period_active_next     = period_active;
    period_pending_next    = period_pending;
    step_cmp_active_next   = step_cmp_active;
    step_cmp_pending_next  = step_cmp_pending;
    servo_cmp_active_next  = servo_cmp_active;
    servo_cmp_pending_next = servo_cmp_pending;
    remaining_steps_next   = remaining_steps;
    counting_on_next       = counting_on;
    step_out_enable_next   = step_out_enable;
    done_flag_next         = done_flag;
    unique case (mode_t'(item.mode))
      MODE_TICK: begin
        if (wrap) begin
          tick_counter_next     = '0;
          period_active_next    = period_pending;
          step_cmp_active_next  = step_cmp_pending;
          servo_cmp_active_next = servo_cmp_pending;
          if (counting_on && remaining_steps != '0) begin
            remaining_steps_next = steps_dec;
            if (steps_dec == '0) begin
              counting_on_next     = 1'b0;
              step_out_enable_next = 1'b0;
              done_flag_next       = 1'b1;
            end
          end
        end else begin
          tick_counter_next = tick_counter + CB'(1);
        end
      end
      MODE_START: begin
        if (item.step_count != '0 && item.step_delay != '0) begin
          period_pending_next   = period_new;
          step_cmp_pending_next = period_new >> 1;
          remaining_steps_next  = item.step_count;
          counting_on_next      = 1'b1;
          step_out_enable_next  = 1'b1;
        end
      end
      MODE_STOP: begin
        counting_on_next     = 1'b0;
        step_out_enable_next = 1'b0;
        remaining_steps_next = '0;
      end
      MODE_SERVO: begin
        servo_cmp_pending_next = CB'(width_clamped);
      end
      MODE_CLEAR: begin
        done_flag_next = 1'b0;
      end
      default: ;
    endcase
  end

  // status of the state after this request
  always_comb begin
    result.step_pin   = step_out_enable_next && (tick_counter_next < step_cmp_active_next);
    result.servo_pin  = tick_counter_next < servo_cmp_active_next;
    result.move_done  = done_flag_next;
    result.moving     = counting_on_next;
    result.steps_left = remaining_steps_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter      <= '0;
      period_active     <= PERIOD_RST;
      period_pending    <= PERIOD_RST;
      step_cmp_active   <= '0;
      step_cmp_pending  <= '0;
      servo_cmp_active  <= SERVO_RST;
      servo_cmp_pending <= SERVO_RST;
      remaining_steps   <= '0;
      counting_on       <= 1'b0;
      step_out_enable   <= 1'b1;
      done_flag         <= 1'b0;
    end else if (advance) begin
      tick_counter      <= tick_counter_next;
      period_active     <= period_active_next;
      period_pending    <= period_pending_next;
      step_cmp_active   <= step_cmp_active_next;
      step_cmp_pending  <= step_cmp_pending_next;
      servo_cmp_active  <= servo_cmp_active_next;
      servo_cmp_pending <= servo_cmp_pending_next;
      remaining_steps   <= remaining_steps_next;
      counting_on       <= counting_on_next;
      step_out_enable   <= step_out_enable_next;
      done_flag         <= done_flag_next;
    end
  end

  `CSPWM_ASSERT_ALWAYS(a_moving_enables_step, !counting_on || step_out_enable)
  `CSPWM_ASSERT_ALWAYS(a_moving_has_steps, !counting_on || remaining_steps != '0)
  `CSPWM_ASSERT_ALWAYS(a_counter_in_period, tick_counter <= period_active)
  `CSPWM_ASSERT_NEXT(a_done_only_on_tick, !done_flag && !is_tick, !done_flag)

endmodule

@@ design/counted_step_and_servo_pwm.sv @@
// requests are held in the input register, then status in the response register
// throughput: one request per cycle unless rsp is stalled; the single-pass state
//   update in cspwm_core and response register sustain back-to-back requests
// reset: synchronous active-high rst; timer state and config return to
//   their power-on values with no clearing pass
// ----------------------------------------------------------------------------
// counted_step_and_servo_pwm
// counted stepper step pulse and servo pwm timer with response register
// ----------------------------------------------------------------------------
module counted_step_and_servo_pwm import cspwm_pkg::*; #(
  parameter int COUNTER_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  cspwm_cmd_if.sink               cmd,
  cspwm_rsp_if.source             rsp,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data
);

  logic      item_valid;
  cmd_item_t item;
  logic      advance;
  rsp_item_t result;
  logic      rsp_valid;
  rsp_item_t rsp_item;

  assign advance = item_valid && (!rsp_valid || rsp.ready);

  cspwm_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  cspwm_core #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .item      (item),
    .result    (result)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_item <= result;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.step_pin   = rsp_item.step_pin;
  assign rsp.servo_pin  = rsp_item.servo_pin;
  assign rsp.move_done  = rsp_item.move_done;
  assign rsp.moving     = rsp_item.moving;
  assign rsp.steps_left = rsp_item.steps_left;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counted_step_and_servo_pwm testbench
// Sends tick and command requests over the valid/ready request channel. An
// in-bench timer model predicts the status responses not fixed by the table, and all are
// compared in order. A directed table covers the reset state, unused modes,
// ignored starts, servo clamping, delay saturation, stop, clear and the first
// counter wraps. Random move sequences with noise follow. They run under
// several servo ranges and three handshake pacing modes, including one long
// response stall.
// ----------------------------------------------------------------------------
module testbench;
  import cspwm_pkg::*;

  localparam int CNT_BITS = 16;
  localparam logic [DELAY_BITS-1:0] DELAY_SAT = DELAY_BITS'(64'd1 << CNT_BITS);
  localparam logic [DELAY_BITS-1:0] DELAY_TOP = '1;
  localparam logic [MODE_BITS-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_BITS-1:0] MODE_SPARE_HI = 3'd7;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    cmd_item_t   req;
    logic [31:0] reps;
    logic        typed;
    rsp_item_t   want;
  } plan_row_t;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]     cfg_data;

  cspwm_cmd_if cmd_ch ();
  cspwm_rsp_if rsp_ch ();

  counted_step_and_servo_pwm #(.COUNTER_BITS(CNT_BITS)) DUT (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // timer model state
  logic [CNT_BITS-1:0]   tick_cnt;
  logic [CNT_BITS-1:0]   period_now;
  logic [CNT_BITS-1:0]   period_next;
  logic [CNT_BITS-1:0]   step_cmp_now;
  logic [CNT_BITS-1:0]   step_cmp_next;
  logic [CNT_BITS-1:0]   servo_cmp_now;
  logic [CNT_BITS-1:0]   servo_cmp_next;
  logic [STEPS_BITS-1:0] steps_togo;
  logic                  counting;
  logic                  step_en;
  logic                  done_flag;
  logic [CFG_BITS-1:0]   servo_lo;
  logic [CFG_BITS-1:0]   servo_hi;

  rsp_item_t status_q[$];
  plan_row_t plan[$];
  rsp_item_t seen_status;
  rsp_item_t due_status;

  int n_sent = 0;
  int n_checked = 0;
  int n_errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_at = 32'h7fff_ffff;
  int hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(50_000_000);
    $display("FAILED: results differ");
    $finish;
  end

  function automatic cmd_item_t req(input logic [MODE_BITS-1:0] mode,
                                    input logic [STEPS_BITS-1:0] count,
                                    input logic [DELAY_BITS-1:0] delay,
                                    input logic [WIDTH_BITS-1:0] width);
    cmd_item_t c;
    c.mode = mode;
    c.step_count = count;
    c.step_delay = delay;
    c.servo_width = width;
    return c;
  endfunction

  // flags are {step_pin, servo_pin, move_done, moving}
  function automatic rsp_item_t status(input logic [3:0] flags,
                                       input logic [STEPS_BITS-1:0] left);
    return rsp_item_t'({flags, left});
  endfunction

  function automatic string fmt_status(input rsp_item_t s);
    return $sformatf("step %b servo %b done %b moving %b left %0d",
                     s.step_pin, s.servo_pin, s.move_done, s.moving, s.steps_left);
  endfunction

  function automatic void plan_add(input logic [MODE_BITS-1:0] mode,
                                   input logic [STEPS_BITS-1:0] count,
                                   input logic [DELAY_BITS-1:0] delay,
                                   input logic [WIDTH_BITS-1:0] width,
                                   input logic [31:0] reps, input logic typed,
                                   input rsp_item_t want);
    plan_row_t r;
    r.req = req(mode, count, delay, width);
    r.reps = reps;
    r.typed = typed;
    r.want = want;
    plan.push_back(r);
  endfunction

  function automatic logic [WIDTH_BITS-1:0] pick_width();
    if ($urandom_range(1) == 0) begin
      return WIDTH_BITS'($urandom());
    end
    return WIDTH_BITS'($urandom_range(0, 12));
  endfunction

  task automatic predict_status(input cmd_item_t c, output rsp_item_t r);
    logic [DELAY_BITS-1:0] delay;
    logic [WIDTH_BITS-1:0] width;
    case (c.mode)
      MODE_TICK: begin
        if (tick_cnt >= period_now) begin
          tick_cnt = '0;
          period_now = period_next;
          step_cmp_now = step_cmp_next;
          servo_cmp_now = servo_cmp_next;
          if (counting && steps_togo != '0) begin
            steps_togo = steps_togo - 1'b1;
            if (steps_togo == '0) begin
              counting = 1'b0;
              step_en = 1'b0;
              done_flag = 1'b1;
            end
          end
        end else begin
          tick_cnt = tick_cnt + 1'b1;
        end
      end
      MODE_START: begin
        if (c.step_count != '0 && c.step_delay != '0) begin
          delay = (c.step_delay > DELAY_SAT) ? DELAY_SAT : c.step_delay;
          period_next = CNT_BITS'(delay - 1'b1);
          step_cmp_next = period_next >> 1;
          steps_togo = c.step_count;
          counting = 1'b1;
          step_en = 1'b1;
        end
      end
      MODE_STOP: begin
        counting = 1'b0;
        step_en = 1'b0;
        steps_togo = '0;
      end
      MODE_SERVO: begin
        width = c.servo_width;
        if (width < servo_lo) begin
          width = servo_lo;
        end
        if (width > servo_hi) begin
          width = servo_hi;
        end
        servo_cmp_next = CNT_BITS'(width);
      end
      MODE_CLEAR: begin
        done_flag = 1'b0;
      end
      default: begin
      end
    endcase
    r.step_pin = step_en && (tick_cnt < step_cmp_now);
    r.servo_pin = tick_cnt < servo_cmp_now;
    r.move_done = done_flag;
    r.moving = counting;
    r.steps_left = steps_togo;
  endtask

  task automatic send_request(input cmd_item_t c, input logic typed, input rsp_item_t want);
    rsp_item_t next_status;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.mode <= c.mode;
    cmd_ch.step_count <= c.step_count;
    cmd_ch.step_delay <= c.step_delay;
    cmd_ch.servo_width <= c.servo_width;
    @(negedge clk);
    while (!cmd_ch.ready) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    predict_status(c, next_status);
    status_q.push_back(typed ? want : next_status);
    n_sent++;
  endtask

  task automatic drain(input int settle);
    cmd_ch.valid <= 1'b0;
    while (status_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_servo_range(input logic [CFG_BITS-1:0] lo, input logic [CFG_BITS-1:0] hi);
    cfg_we <= 1'b1;
    cfg_index <= REG_SERVO_MIN;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= REG_SERVO_MAX;
    cfg_data <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    servo_lo = lo;
    servo_hi = hi;
  endtask

  task automatic random_traffic(input int n_items);
    int first;
    int ticks;
    logic [STEPS_BITS-1:0] count;
    first = n_sent;
    while (n_sent - first < n_items) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5, 6: begin
          count = ($urandom_range(7) == 0) ? STEPS_BITS'($urandom())
                                           : STEPS_BITS'($urandom_range(1, 5));
          // a long delay start is always overridden before the next wrap
          if ($urandom_range(4) == 0) begin
            send_request(req(MODE_START, STEPS_BITS'($urandom()),
                             DELAY_BITS'($urandom_range(1, DELAY_TOP)), pick_width()),
                         1'b0, '0);
          end
          send_request(req(MODE_START, count, DELAY_BITS'($urandom_range(1, 6)),
                           pick_width()), 1'b0, '0);
          ticks = $urandom_range(2, 40);
          repeat (ticks) begin
            if ($urandom_range(9) == 0) begin
              send_request(req(MODE_SERVO, STEPS_BITS'($urandom()),
                               DELAY_BITS'($urandom()), pick_width()), 1'b0, '0);
            end else begin
              send_request(req(MODE_TICK, STEPS_BITS'($urandom()),
                               DELAY_BITS'($urandom()), WIDTH_BITS'($urandom())), 1'b0, '0);
            end
          end
          if (count > 5 || $urandom_range(3) == 0) begin
            send_request(req(MODE_STOP, STEPS_BITS'($urandom()), DELAY_BITS'($urandom()),
                             WIDTH_BITS'($urandom())), 1'b0, '0);
          end
          if ($urandom_range(1) == 0) begin
            send_request(req(MODE_CLEAR, STEPS_BITS'($urandom()), DELAY_BITS'($urandom()),
                             WIDTH_BITS'($urandom())), 1'b0, '0);
          end
        end
        7: begin
          send_request(req(MODE_SERVO, STEPS_BITS'($urandom()), DELAY_BITS'($urandom()),
                           pick_width()), 1'b0, '0);
        end
        8: begin
          case ($urandom_range(3))
            0: send_request(req(MODE_BITS'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)),
                                STEPS_BITS'($urandom()), DELAY_BITS'($urandom()),
                                WIDTH_BITS'($urandom())), 1'b0, '0);
            1: send_request(req(MODE_START, '0, DELAY_BITS'($urandom()),
                                WIDTH_BITS'($urandom())), 1'b0, '0);
            2: send_request(req(MODE_START, STEPS_BITS'($urandom()), '0,
                                WIDTH_BITS'($urandom())), 1'b0, '0);
            default: send_request(req($urandom_range(1) ? MODE_STOP : MODE_CLEAR,
                                      STEPS_BITS'($urandom()), DELAY_BITS'($urandom()),
                                      WIDTH_BITS'($urandom())), 1'b0, '0);
          endcase
        end
        default: begin
          send_request(req(MODE_TICK, STEPS_BITS'($urandom()), DELAY_BITS'($urandom()),
                           WIDTH_BITS'($urandom())), 1'b0, '0);
        end
      endcase
    end
  endtask

  // response side pacing, with one long hold-off in the unpaced phase
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (n_checked >= hold_at) begin
        hold_left = HOLD_CYCLES;
        hold_at = 32'h7fff_ffff;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      seen_status.step_pin = rsp_ch.step_pin;
      seen_status.servo_pin = rsp_ch.servo_pin;
      seen_status.move_done = rsp_ch.move_done;
      seen_status.moving = rsp_ch.moving;
      seen_status.steps_left = rsp_ch.steps_left;
      n_checked++;
      if (status_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
          $display("%0t: unexpected response: %s", $time, fmt_status(seen_status));
        end
      end else begin
        due_status = status_q.pop_front();
        if (seen_status.step_pin !== due_status.step_pin
            || seen_status.servo_pin !== due_status.servo_pin
            || seen_status.move_done !== due_status.move_done
            || seen_status.moving !== due_status.moving
            || seen_status.steps_left !== due_status.steps_left) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS) begin
            $display("%0t: response %0d mismatch", $time, n_checked);
            $display("  expected %s", fmt_status(due_status));
            $display("  actual   %s", fmt_status(seen_status));
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.mode = '0;
    cmd_ch.step_count = '0;
    cmd_ch.step_delay = '0;
    cmd_ch.servo_width = '0;

    tick_cnt = '0;
    period_now = CNT_BITS'(RESET_PERIOD);
    period_next = CNT_BITS'(RESET_PERIOD);
    step_cmp_now = '0;
    step_cmp_next = '0;
    servo_cmp_now = CNT_BITS'(RESET_SERVO_CMP);
    servo_cmp_next = CNT_BITS'(RESET_SERVO_CMP);
    steps_togo = '0;
    counting = 1'b0;
    step_en = 1'b1;
    done_flag = 1'b0;
    servo_lo = RESET_SERVO_MIN;
    servo_hi = RESET_SERVO_MAX;

    // reset state, unused modes, ignored starts, clamping at reset range
    plan_add(MODE_TICK, 32'd0, 17'd0, 16'd0, 32'd1, 1'b1, status(4'b0100, 32'd0));
    plan_add(MODE_SPARE_LO, 32'd7, 17'd9, 16'd3, 32'd1, 1'b1, status(4'b0100, 32'd0));
    plan_add(MODE_SPARE_HI, '1, '1, '1, 32'd1, 1'b1, status(4'b0100, 32'd0));
    plan_add(MODE_START, 32'd0, 17'd5, 16'd0, 32'd1, 1'b1, status(4'b0100, 32'd0));
    plan_add(MODE_START, 32'd5, 17'd0, 16'd0, 32'd1, 1'b1, status(4'b0100, 32'd0));
    plan_add(MODE_SERVO, 32'd0, 17'd0, 16'd0, 32'd1, 1'b1, status(4'b0100, 32'd0));
    plan_add(MODE_SERVO, 32'd0, 17'd0, '1, 32'd1, 1'b1, status(4'b0100, 32'd0));
    plan_add(MODE_STOP, 32'd0, 17'd0, 16'd0, 32'd1, 1'b1, status(4'b0100, 32'd0));
    plan_add(MODE_CLEAR, 32'd0, 17'd0, 16'd0, 32'd1, 1'b1, status(4'b0100, 32'd0));
    // largest count and exact saturation boundary, then overridden pending period
    plan_add(MODE_START, '1, DELAY_SAT, 16'd0, 32'd1, 1'b1, status(4'b0101, '1));
    plan_add(MODE_START, 32'd2, 17'd1, 16'd0, 32'd1, 1'b1, status(4'b0101, 32'd2));
    // run out the power-on period
    plan_add(MODE_TICK, 32'd0, 17'd0, 16'd0, 32'd19998, 1'b0, '0);
    plan_add(MODE_TICK, 32'd0, 17'd0, 16'd0, 32'd1, 1'b1, status(4'b0101, 32'd1));
    plan_add(MODE_TICK, 32'd0, 17'd0, 16'd0, 32'd1, 1'b1, status(4'b0110, 32'd0));
    plan_add(MODE_TICK, 32'd0, 17'd0, 16'd0, 32'd1, 1'b1, status(4'b0110, 32'd0));
    plan_add(MODE_CLEAR, 32'd0, 17'd0, 16'd0, 32'd1, 1'b1, status(4'b0100, 32'd0));
    // delay above the span saturates to the full counter range
    plan_add(MODE_START, 32'd3, DELAY_TOP, 16'd0, 32'd1, 1'b1, status(4'b0101, 32'd3));
    plan_add(MODE_TICK, 32'd0, 17'd0, 16'd0, 32'd1, 1'b1, status(4'b1101, 32'd2));
    plan_add(MODE_START, 32'd1, 17'd2, 16'd0, 32'd1, 1'b1, status(4'b1101, 32'd1));
    plan_add(MODE_TICK, 32'd0, 17'd0, 16'd0, 32'd65535, 1'b0, '0);
    plan_add(MODE_TICK, 32'd0, 17'd0, 16'd0, 32'd1, 1'b1, status(4'b0110, 32'd0));
    // stop leaves the done flag alone
    plan_add(MODE_START, 32'd5, 17'd3, 16'd0, 32'd1, 1'b1, status(4'b0111, 32'd5));
    plan_add(MODE_STOP, 32'd0, 17'd0, 16'd0, 32'd1, 1'b1, status(4'b0110, 32'd0));
    plan_add(MODE_TICK, 32'd0, 17'd0, 16'd0, 32'd1, 1'b1, status(4'b0110, 32'd0));
    plan_add(MODE_CLEAR, 32'd0, 17'd0, 16'd0, 32'd1, 1'b1, status(4'b0100, 32'd0));

    send_idle_pct = 18;
    recv_idle_pct = 68;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      repeat (plan[i].reps) send_request(plan[i].req, plan[i].typed, plan[i].want);
    end

    drain(4);
    set_servo_range('0, '1);
    random_traffic(310);

    drain(4);
    send_idle_pct = 68;
    recv_idle_pct = 18;
    set_servo_range(16'd2, 16'd5);
    random_traffic(310);

    // min above max: max wins
    drain(4);
    set_servo_range(16'd9, 16'd3);
    random_traffic(310);

    drain(4);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_at = n_checked + 40;
    set_servo_range('1, '0);
    random_traffic(310);

    drain(20);
    if (status_q.size() != 0) begin
      n_errors++;
    end
    $display("%0d requests sent, %0d status responses checked, %0d mismatches",
             n_sent, n_checked, n_errors);
    $display("covered reset state, ignored starts, delay saturation, five servo ranges, "
             , "three pacing modes and a long response stall");
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
